/* rtl/sgb_pkg.sv */
// Shared types, constants and rounding for the separable blur.
// Used by every module of the block; no dependencies.
package sgb_pkg;

   localparam int MAX_TAPS   = 9;
   localparam int HALF_MAX   = (MAX_TAPS - 1) / 2;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int SUM_W      = 28;
   localparam int SLOT_W     = 4;
   localparam int HALF_W     = 3;
   localparam int FRAC_BITS  = 15;
   localparam int ROUND_BIAS = 16384;
   localparam int PIX_MAX    = 255;

   localparam logic MODE_PIXEL = 1'b0;

   typedef enum logic [2:0] {
      REG_WIDTH   = 3'd0,
      REG_HEIGHT  = 3'd1,
      REG_HALF    = 3'd2,
      REG_TAPS_LO = 3'd3,
      REG_TAPS_HI = 3'd4,
      REG_TAP8    = 3'd5
   } csr_index_type;

   typedef logic [MAX_TAPS-1:0][PIX_W-1:0]  sample_vec_type;
   typedef logic [MAX_TAPS-1:0][SLOT_W-1:0] slot_vec_type;
   typedef logic [MAX_TAPS-1:0][COEF_W-1:0] coef_vec_type;

   typedef struct packed {
      logic valid;
      logic last_row;
      logic last_frame;
   } emit_type;

   typedef struct packed {
      logic              wvalid;
      logic [SLOT_W-1:0] wslot;
      sample_vec_type    samples;
      emit_type          em;
      slot_vec_type      vslots;
   } job_type;

   function automatic logic [PIX_W-1:0] round_sat(input logic [SUM_W-1:0] sum);
      logic [SUM_W:0]           t;
      logic [SUM_W-FRAC_BITS:0] v;
      t = {1'b0, sum} + (SUM_W+1)'(ROUND_BIAS);
      v = t[SUM_W:FRAC_BITS];
      if (v > (SUM_W-FRAC_BITS+1)'(PIX_MAX)) begin
         return PIX_W'(PIX_MAX);
      end
      return v[PIX_W-1:0];
   endfunction

endpackage

/* rtl/sgb_tap_cell.sv */
// One multiply-accumulate cell of the tap chain.
// Depends on sgb_pkg.
module sgb_tap_cell (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [sgb_pkg::SUM_W-1:0]  sum_prev,
   input  logic [sgb_pkg::PIX_W-1:0]  sample,
   input  logic [sgb_pkg::COEF_W-1:0] coef,
   output logic [sgb_pkg::SUM_W-1:0]  sum_out
);
   import sgb_pkg::*;

   logic [PIX_W+COEF_W-1:0] prod;
   logic [SUM_W-1:0]        acc_in;
   logic [SUM_W-1:0]        acc_ff;

   assign prod   = {{COEF_W{1'b0}}, sample} * {{PIX_W{1'b0}}, coef};
   assign acc_in = sum_prev + SUM_W'(prod);

   always_ff @(posedge clock) begin
      if (enable) begin
         acc_ff <= acc_in;
      end
   end

   assign sum_out = acc_ff;
endmodule

/* rtl/sgb_line_store.sv */
// Line store: one word per column holding the horizontal results of all ring rows.
// Byte-lane write, registered read. Depends on sgb_pkg.
module sgb_line_store #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
   input  logic [sgb_pkg::SLOT_W-1:0]     wr_slot,
   input  logic [sgb_pkg::PIX_W-1:0]      wr_data,
   input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   output sgb_pkg::sample_vec_type        rd_data
);
   import sgb_pkg::*;

   sample_vec_type mem [MAX_WIDTH];
   sample_vec_type rd_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (wr_en) begin
            mem[wr_addr][wr_slot] <= wr_data;
         end
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule

/* rtl/sgb_ctrl.sv */
// Stream control: raster counters, row window, readiness and job sequencing.
// Emits one job per cycle into the tap chains while advance is high. Depends on sgb_pkg.
module sgb_ctrl #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          stream_clear,
   input  logic [$clog2(MAX_WIDTH):0]    eff_width,
   input  logic [15:0]                   eff_height,
   input  logic [sgb_pkg::HALF_W-1:0]    eff_half,
   input  logic                          in_valid,
   input  logic                          in_mode,
   input  logic [sgb_pkg::PIX_W-1:0]     in_pixel,
   output logic                          in_ready,
   output sgb_pkg::job_type              job,
   output logic [$clog2(MAX_WIDTH)-1:0]  job_wx,
   output logic [$clog2(MAX_WIDTH)-1:0]  job_ox
);
   import sgb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;

   logic [CW-1:0]     in_col_ff, out_col_ff;
   logic [15:0]       in_row_ff, out_row_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff;
   sample_vec_type    window_ff;

   logic              rec_valid_ff, rec_wr_ff;
   logic [CW-1:0]     rec_x_ff, rec_end_ff, rec_c_ff, rec_ox_ff;
   logic [SLOT_W-1:0] rec_wslot_ff;
   emit_type          rec_em_ff;
   slot_vec_type      rec_vslots_ff;

   job_type           job_ff, job_in;
   logic [CW-1:0]     job_wx_ff, job_ox_ff;

   logic              accept, rec_last, pix, wr;
   logic [CW-1:0]     x_lo, x_end;
   logic [CW-1:0]     in_col_in, out_col_in;
   logic [15:0]       in_row_in, out_row_in;
   logic [SLOT_W-1:0] in_slot_in, out_slot_in;
   emit_type          em;
   slot_vec_type      vslots;
   logic [WW-1:0]     w_m1;

   assign accept   = in_valid && in_ready;
   assign rec_last = !rec_wr_ff || (rec_x_ff == rec_end_ff);
   assign in_ready = advance && (!rec_valid_ff || rec_last);
   assign w_m1     = eff_width - WW'(1);

   // one stream step: pixel intake, then at most one output
   always_comb begin
      logic [WW-1:0] c_ext, inc, c_need;
      logic          row_end, c_ge_h, out_live, ready;
      logic [16:0]   r_need, r_lim;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      c_ext   = {1'b0, in_col_ff};
      inc     = c_ext + WW'(1);
      pix     = (in_mode == MODE_PIXEL) && (in_row_ff < eff_height) && (c_ext < eff_width);
      row_end = (c_ext == w_m1);
      c_ge_h  = (c_ext >= WW'(eff_half));
      x_lo    = c_ge_h ? (in_col_ff - CW'(eff_half)) : '0;
      x_end   = row_end ? w_m1[CW-1:0] : x_lo;
      wr      = pix && (row_end || c_ge_h);
      if (pix) begin
         if (inc >= eff_width) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 16'd1;
            in_slot_in = (in_slot_ff == SLOT_W'(MAX_TAPS - 1)) ? '0 : in_slot_ff + SLOT_W'(1);
         end else begin
            in_col_in = inc[CW-1:0];
         end
      end
      out_live = (out_row_ff < eff_height) && ({1'b0, out_col_ff} < eff_width);
      r_need   = {1'b0, out_row_ff} + 17'(eff_half);
      r_lim    = {1'b0, eff_height} - 17'd1;
      if (r_need > r_lim) begin
         r_need = r_lim;
      end
      c_need = {1'b0, out_col_ff} + WW'(eff_half);
      if (c_need > w_m1) begin
         c_need = w_m1;
      end
      ready = out_live && (({1'b0, in_row_in} > r_need) ||
              (({1'b0, in_row_in} == r_need) && ({1'b0, in_col_in} > c_need)));
      em.valid      = ready;
      em.last_row   = ({1'b0, out_col_ff} == w_m1);
      em.last_frame = em.last_row && ({1'b0, out_row_ff} == r_lim);
      if (ready) begin
         if (em.last_row) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 16'd1;
            out_slot_in = (out_slot_ff == SLOT_W'(MAX_TAPS - 1)) ? '0 : out_slot_ff + SLOT_W'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
         if (em.last_frame) begin
            in_col_in   = '0;
            in_row_in   = '0;
            in_slot_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_slot_in = '0;
         end
      end
   end

   // ring slots of the clamped rows feeding the vertical taps
   always_comb begin
      logic signed [4:0]  d;
      logic signed [17:0] sy;
      logic signed [4:0]  t;
      logic [16:0]        top_gap;
      top_gap = {1'b0, eff_height} - 17'd1 - {1'b0, out_row_ff};
      for (int k = 0; k < MAX_TAPS; k++) begin
         d  = $signed(5'(k)) - $signed({2'b00, eff_half});
         sy = $signed({2'b00, out_row_ff}) + 18'(d);
         if (sy < 0) begin
            t = '0;
         end else begin
            if (sy > $signed({2'b00, eff_height}) - 18'sd1) begin
               t = $signed({1'b0, out_slot_ff}) + $signed(top_gap[4:0]);
            end else begin
               t = $signed({1'b0, out_slot_ff}) + d;
            end
            if (t < 0) begin
               t = t + 5'sd9;
            end else if (t >= 5'sd9) begin
               t = t - 5'sd9;
            end
         end
         vslots[k] = t[SLOT_W-1:0];
      end
   end

   // job issued from the current step record
   always_comb begin
      logic [WW-1:0]     xk;
      logic [SLOT_W-1:0] e, idx;
      e = SLOT_W'(rec_c_ff - rec_x_ff);
      job_in.wvalid = rec_valid_ff && rec_wr_ff;
      job_in.wslot  = rec_wslot_ff;
      job_in.vslots = rec_vslots_ff;
      job_in.em     = (rec_valid_ff && rec_last) ? rec_em_ff : '0;
      for (int k = 0; k < MAX_TAPS; k++) begin
         xk = {1'b0, rec_x_ff} + WW'(k);
         if (xk < WW'(eff_half)) begin
            idx = rec_c_ff[SLOT_W-1:0];
         end else if (xk > w_m1 + WW'(eff_half)) begin
            idx = '0;
         end else begin
            idx = e + SLOT_W'(eff_half) - SLOT_W'(k);
         end
         job_in.samples[k] = (idx < SLOT_W'(MAX_TAPS)) ? window_ff[idx] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         rec_valid_ff <= 1'b0;
         job_ff       <= '0;
      end else if (stream_clear) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         rec_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_col_ff   <= in_col_in;
            in_row_ff   <= in_row_in;
            in_slot_ff  <= in_slot_in;
            out_col_ff  <= out_col_in;
            out_row_ff  <= out_row_in;
            out_slot_ff <= out_slot_in;
         end
         if (advance) begin
            job_ff <= job_in;
            if (accept) begin
               rec_valid_ff <= wr || em.valid;
            end else if (rec_valid_ff && rec_last) begin
               rec_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (accept && pix) begin
         window_ff <= {window_ff[MAX_TAPS-2:0], in_pixel};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         job_wx_ff <= rec_x_ff;
         job_ox_ff <= rec_ox_ff;
         if (accept) begin
            rec_wr_ff     <= wr;
            rec_x_ff      <= x_lo;
            rec_end_ff    <= x_end;
            rec_c_ff      <= in_col_ff;
            rec_wslot_ff  <= in_slot_ff;
            rec_em_ff     <= em;
            rec_ox_ff     <= out_col_ff;
            rec_vslots_ff <= vslots;
         end else if (rec_valid_ff && !rec_last) begin
            rec_x_ff <= rec_x_ff + CW'(1);
         end
      end
   end

   assign job    = job_ff;
   assign job_wx = job_wx_ff;
   assign job_ox = job_ox_ff;

endmodule

/* rtl/separable_gaussian_blur.sv */
// Separable blur, replicated borders, one 8-bit plane in raster order.
// Results go through the job register, horizontal chain, line store, vertical chain
// and output register; results due at a row end follow its border writes.
// Throughput: one transaction per cycle while the pipeline advances; a pixel
// ending a row holds input while right-border columns are written (one store port).
// Reset: synchronous; counters, handshakes and control registers return to defaults; the line
// store is not cleared, and slots read for unused taps are masked to zero.
module separable_gaussian_blur #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_last_of_row,
   output logic        rsp_last_of_frame,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import sgb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [11:0]       width_ff;
   logic [15:0]       height_ff;
   logic [HALF_W-1:0] half_ff;
   logic [63:0]       taps_lo_ff, taps_hi_ff;
   logic [15:0]       tap8_ff;
   logic              stream_clear;

   logic [CW:0]       eff_w;
   logic [15:0]       eff_h;
   logic [HALF_W-1:0] eff_half;
   coef_vec_type      tap_raw, coef;

   logic              advance, out_take;
   job_type           job0;
   logic [CW-1:0]     wx0, ox0;
   job_type           js_ff [1:11];
   logic [CW-1:0]     wx_ff [1:9];
   logic [CW-1:0]     ox_ff [1:10];
   logic [SUM_W-1:0]  hsum [MAX_TAPS];
   logic [SUM_W-1:0]  vsum [MAX_TAPS];
   sample_vec_type    rd_data, vsel;
   sample_vec_type    vs_ff [0:8];
   emit_type          vf_ff [0:9];

   logic              rsp_valid_ff, rsp_last_row_ff, rsp_last_frame_ff;
   logic [PIX_W-1:0]  rsp_pixel_ff;

   assign stream_clear = csr_we && (csr_index <= REG_TAP8);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 12'd2048;
         height_ff  <= 16'd1;
         half_ff    <= '0;
         taps_lo_ff <= 64'd32768;
         taps_hi_ff <= '0;
         tap8_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:   width_ff   <= csr_wdata[11:0];
            REG_HEIGHT:  height_ff  <= csr_wdata[15:0];
            REG_HALF:    half_ff    <= csr_wdata[HALF_W-1:0];
            REG_TAPS_LO: taps_lo_ff <= csr_wdata;
            REG_TAPS_HI: taps_hi_ff <= csr_wdata;
            REG_TAP8:    tap8_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = (CW+1)'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = (CW+1)'(MAX_WIDTH);
      end else begin
         eff_w = (CW+1)'(width_ff);
      end
      eff_h    = (height_ff == '0) ? 16'd1 : height_ff;
      eff_half = (half_ff > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : half_ff;
   end

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_coef
      if (k < 4) begin : g_lo
         assign tap_raw[k] = taps_lo_ff[16*k +: 16];
      end else if (k < 8) begin : g_hi
         assign tap_raw[k] = taps_hi_ff[16*(k-4) +: 16];
      end else begin : g_top
         assign tap_raw[k] = tap8_ff;
      end
      assign coef[k] = (4'(k) <= {eff_half, 1'b0}) ? tap_raw[k] : '0;
   end

   assign out_take = rsp_ready || !rsp_valid_ff;
   assign advance  = out_take || !vf_ff[9].valid;

   sgb_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .stream_clear (stream_clear),
      .eff_width    (eff_w),
      .eff_height   (eff_h),
      .eff_half     (eff_half),
      .in_valid     (req_valid),
      .in_mode      (req_mode),
      .in_pixel     (req_pixel_in),
      .in_ready     (req_ready),
      .job          (job0),
      .job_wx       (wx0),
      .job_ox       (ox0)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         js_ff <= '{default: '0};
         vf_ff <= '{default: '0};
      end else if (advance) begin
         js_ff[1] <= job0;
         for (int k = 2; k <= 11; k++) begin
            js_ff[k] <= js_ff[k-1];
         end
         vf_ff[0] <= js_ff[11].em;
         for (int k = 1; k <= 9; k++) begin
            vf_ff[k] <= vf_ff[k-1];
         end
      end
   end

   // unused taps read rows that may not be written yet
   always_comb begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         vsel[k] = (4'(k) <= {eff_half, 1'b0}) ? rd_data[js_ff[11].vslots[k]] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wx_ff[1] <= wx0;
         ox_ff[1] <= ox0;
         for (int k = 2; k <= 9; k++) begin
            wx_ff[k] <= wx_ff[k-1];
         end
         for (int k = 2; k <= 10; k++) begin
            ox_ff[k] <= ox_ff[k-1];
         end
         vs_ff[0] <= vsel;
         for (int k = 1; k <= 8; k++) begin
            vs_ff[k] <= vs_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_hcell
      sgb_tap_cell u_cell (
         .clock    (clock),
         .enable   (advance),
         .sum_prev ((k == 0) ? SUM_W'(0) : hsum[(k == 0) ? 0 : k-1]),
         .sample   ((k == 0) ? job0.samples[0] : js_ff[(k == 0) ? 1 : k].samples[k]),
         .coef     (coef[k]),
         .sum_out  (hsum[k])
      );
   end

   sgb_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
      .clock   (clock),
      .enable  (advance),
      .wr_en   (js_ff[9].wvalid),
      .wr_addr (wx_ff[9]),
      .wr_slot (js_ff[9].wslot),
      .wr_data (round_sat(hsum[MAX_TAPS-1])),
      .rd_addr (ox_ff[10]),
      .rd_data (rd_data)
   );

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_vcell
      sgb_tap_cell u_cell (
         .clock    (clock),
         .enable   (advance),
         .sum_prev ((k == 0) ? SUM_W'(0) : vsum[(k == 0) ? 0 : k-1]),
         .sample   (vs_ff[k][k]),
         .coef     (coef[k]),
         .sum_out  (vsum[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= vf_ff[9].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_pixel_ff      <= round_sat(vsum[MAX_TAPS-1]);
         rsp_last_row_ff   <= vf_ff[9].last_row;
         rsp_last_frame_ff <= vf_ff[9].last_frame;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = rsp_pixel_ff;
   assign rsp_last_of_row   = rsp_last_row_ff;
   assign rsp_last_of_frame = rsp_last_frame_ff;

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_last_of_row)
      else $error("frame end without row end");

   a_no_intake_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !advance |-> !req_ready)
      else $error("input taken while pipeline blocked");

   a_blocked_result_held: assert property (@(posedge clock) disable iff (reset)
      vf_ff[9].valid && !advance |=> vf_ff[9].valid)
      else $error("blocked result dropped");

endmodule
